// ----- src/u8sv_pkg.sv -----
package u8sv_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned OutDataW = 8;

  localparam logic [ByteW-1:0] MaskTop3 = 8'he0;
  localparam logic [ByteW-1:0] MaskTop2 = 8'hc0;
  localparam logic [ByteW-1:0] MaskTop4 = 8'hf0;
  localparam logic [ByteW-1:0] MaskTop5 = 8'hf8;
  localparam logic [ByteW-1:0] MaskTop7 = 8'hfe;
  localparam logic [ByteW-1:0] ContTag = 8'h80;
  localparam logic [ByteW-1:0] Lead2Tag = 8'hc0;
  localparam logic [ByteW-1:0] Lead3Tag = 8'he0;
  localparam logic [ByteW-1:0] Lead4Tag = 8'hf0;
  localparam logic [ByteW-1:0] SurrLead = 8'hed;
  localparam logic [ByteW-1:0] SurrTag = 8'ha0;
  localparam logic [ByteW-1:0] NoncharLead = 8'hef;
  localparam logic [ByteW-1:0] NoncharMid = 8'hbf;
  localparam logic [ByteW-1:0] NoncharTail = 8'hbe;
  localparam logic [ByteW-1:0] MaxLead = 8'hf4;
  localparam logic [ByteW-1:0] MaxSecond = 8'h8f;

  // Lead bytes whose second byte needs an extra range check.
  typedef enum logic [2:0] {
    LEAD_OTHER,
    LEAD_E0,
    LEAD_ED,
    LEAD_EF,
    LEAD_F0,
    LEAD_F4
  } lead_kind_e;

  typedef struct packed {
    logic       last;
    logic       is_zero;
    logic       is_ascii;
    logic       lead2;
    logic       lead3;
    logic       lead4;
    logic       lead_err;
    lead_kind_e kind;
    logic       cont_ok;
    logic       e0_low;
    logic       ed_high;
    logic       f0_low;
    logic       f4_high;
    logic       nc_mid;
    logic       nc_tail;
  } byte_class_t;

  function automatic byte_class_t classify(logic [ByteW-1:0] b, logic last);
    byte_class_t c;
    c.last     = last;
    c.is_zero  = (b == '0);
    c.is_ascii = ~b[ByteW-1];
    c.lead2    = ((b & MaskTop3) == Lead2Tag);
    c.lead3    = ((b & MaskTop4) == Lead3Tag);
    c.lead4    = ((b & MaskTop5) == Lead4Tag);
    // Overlong two-byte leads, leads beyond U+10FFFF and stray bytes.
    c.lead_err = (c.lead2 && ((b & MaskTop7) == Lead2Tag)) ||
                 (c.lead4 && (b > MaxLead)) ||
                 (b[ByteW-1] && !c.lead2 && !c.lead3 && !c.lead4);
    case (b)
      Lead3Tag:    c.kind = LEAD_E0;
      SurrLead:    c.kind = LEAD_ED;
      NoncharLead: c.kind = LEAD_EF;
      Lead4Tag:    c.kind = LEAD_F0;
      MaxLead:     c.kind = LEAD_F4;
      default:     c.kind = LEAD_OTHER;
    endcase
    c.cont_ok = ((b & MaskTop2) == ContTag);
    c.e0_low  = ((b & MaskTop3) == ContTag);
    c.ed_high = ((b & MaskTop3) == SurrTag);
    c.f0_low  = ((b & MaskTop4) == ContTag);
    c.f4_high = (b > MaxSecond);
    c.nc_mid  = (b == NoncharMid);
    c.nc_tail = ((b & MaskTop7) == NoncharTail);
    return c;
  endfunction

endpackage

// ----- src/u8sv_front.sv -----
module u8sv_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,
  input  logic                  s_axis_tlast,
  output logic                  cls_valid_o,
  input  logic                  cls_ready_i,
  output u8sv_pkg::byte_class_t cls_o
);
  import u8sv_pkg::*;

  logic        valid_q, valid_d;
  byte_class_t cls_q;

  assign s_axis_tready = !valid_q || cls_ready_i;
  assign valid_d = (s_axis_tvalid && s_axis_tready) || (valid_q && !cls_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cls_q <= classify(s_axis_tdata, s_axis_tlast);
    end
  end

  assign cls_valid_o = valid_q;
  assign cls_o = cls_q;
endmodule

// ----- src/u8sv_fifo.sv -----
module u8sv_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_valid_i,
  output logic                  wr_ready_o,
  input  u8sv_pkg::byte_class_t wr_data_i,
  output logic                  rd_valid_o,
  input  logic                  rd_ready_i,
  output u8sv_pkg::byte_class_t rd_data_o
);
  import u8sv_pkg::*;

  byte_class_t mem_q [2];
  logic        wptr_q, wptr_d;
  logic        rptr_q, rptr_d;
  logic [1:0]  count_q, count_d;
  logic        push, pop;

  assign wr_ready_o = (count_q != 2'd2);
  assign rd_valid_o = (count_q != 2'd0);
  assign push = wr_valid_i && wr_ready_o;
  assign pop  = rd_valid_o && rd_ready_i;

  always_comb begin
    wptr_d  = wptr_q ^ push;
    rptr_d  = rptr_q ^ pop;
    count_d = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

  assign rd_data_o = mem_q[rptr_q];
endmodule

// ----- src/u8sv_back.sv -----
module u8sv_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cls_valid_i,
  output logic                  cls_ready_o,
  input  u8sv_pkg::byte_class_t cls_i,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [7:0]            m_axis_tdata
);
  import u8sv_pkg::*;

  logic [1:0] pend_q, pend_d;
  lead_kind_e kind_q, kind_d;
  logic       second_q, second_d;
  logic       nc_q, nc_d;
  logic       err_q, err_d;
  logic       stop_q, stop_d;
  logic       out_valid_q, out_valid_d;
  logic       out_flag_q;
  logic       take;

  // A byte that ends a string needs the output register; others never wait on it.
  assign cls_ready_o = !cls_i.last || !out_valid_q || m_axis_tready;
  assign take = cls_valid_i && cls_ready_o;

  always_comb begin
    pend_d   = pend_q;
    kind_d   = kind_q;
    second_d = second_q;
    nc_d     = nc_q;
    err_d    = err_q;
    stop_d   = stop_q;
    if (!err_q && !stop_q) begin
      if (pend_q == 2'd0) begin
        if (cls_i.is_zero) begin
          stop_d = 1'b1;
        end else if (!cls_i.is_ascii) begin
          err_d = cls_i.lead_err;
          if (cls_i.lead2 || cls_i.lead3 || cls_i.lead4) begin
            kind_d   = cls_i.kind;
            second_d = 1'b1;
            pend_d   = cls_i.lead2 ? 2'd1 : (cls_i.lead3 ? 2'd2 : 2'd3);
          end
        end
      end else if (!cls_i.cont_ok) begin
        err_d = 1'b1;
      end else begin
        if (second_q) begin
          err_d = (kind_q == LEAD_E0 && cls_i.e0_low) ||
                  (kind_q == LEAD_ED && cls_i.ed_high) ||
                  (kind_q == LEAD_F0 && cls_i.f0_low) ||
                  (kind_q == LEAD_F4 && cls_i.f4_high);
          nc_d = (kind_q == LEAD_EF) && cls_i.nc_mid;
          second_d = 1'b0;
        end else begin
          err_d = nc_q && (pend_q == 2'd1) && cls_i.nc_tail;
          nc_d  = 1'b0;
        end
        pend_d = pend_q - 2'd1;
      end
    end
  end

  assign out_valid_d = (take && cls_i.last) || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 2'd0;
      kind_q      <= LEAD_OTHER;
      second_q    <= 1'b0;
      nc_q        <= 1'b0;
      err_q       <= 1'b0;
      stop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (take) begin
        if (cls_i.last) begin
          pend_q   <= 2'd0;
          kind_q   <= LEAD_OTHER;
          second_q <= 1'b0;
          nc_q     <= 1'b0;
          err_q    <= 1'b0;
          stop_q   <= 1'b0;
        end else begin
          pend_q   <= pend_d;
          kind_q   <= kind_d;
          second_q <= second_d;
          nc_q     <= nc_d;
          err_q    <= err_d;
          stop_q   <= stop_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && cls_i.last) begin
      out_flag_q <= err_d || (pend_d != 2'd0);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW-1){1'b0}}, out_flag_q};
endmodule

// ----- src/utf8_stream_validator_unit.sv -----
// Checks strings for valid UTF-8, one byte per transaction on the slave side,
// with tlast on the final byte of each string. One verdict per string leaves on
// the master side (tdata bit 0: 1 = invalid) once its final byte has passed the
// classifier register, the two-entry queue and the verdict register. Bytes are
// taken one every cycle while the master side does not stall, also across string
// boundaries: the per-byte decode state is one small register set updated on each
// byte, and the queue plus the verdict register keep the slave side running while
// the master side stalls, until a further final byte must wait. A zero byte in
// lead position ends checking for the rest of that string.
module utf8_stream_validator_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // [7:0] data_byte
  input  logic       s_axis_tlast,  // last_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata   // [0] invalid_flag, [7:1] zero
);
  import u8sv_pkg::*;

  logic        f_valid, f_ready;
  byte_class_t f_cls;
  logic        q_valid, q_ready;
  byte_class_t q_cls;

  u8sv_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .cls_valid_o   (f_valid),
    .cls_ready_i   (f_ready),
    .cls_o         (f_cls)
  );

  u8sv_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (f_valid),
    .wr_ready_o (f_ready),
    .wr_data_i  (f_cls),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_ready),
    .rd_data_o  (q_cls)
  );

  u8sv_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cls_valid_i   (q_valid),
    .cls_ready_o   (q_ready),
    .cls_i         (q_cls),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );
endmodule
